### sv/zsee_pkg.sv
// Shared types, constants and name table for the ZIP stored-entry extractor.
// Used by zsee_front, zsee_queue, zsee_back and zip_stored_entry_extractor_top.
`default_nettype none

package zsee_pkg;

  // Local file header layout
  localparam logic [31:0] ZIP_MAGIC  = 32'h04034b50;
  localparam logic [4:0]  HDR_LEN    = 5'd30;
  localparam logic [4:0]  OFS_METHOD = 5'd8;
  localparam logic [4:0]  OFS_SIZE   = 5'd18;
  localparam logic [4:0]  OFS_NAME   = 5'd26;
  localparam logic [4:0]  OFS_EXTRA  = 5'd28;

  // Name length an entry must have to match; table names are this long
  localparam logic [15:0] NAME_BYTES = 16'd20;
  localparam int unsigned NAME_BITS  = 160;

  // Binning values that select a table row; anything else selects row 0
  localparam logic [3:0] BIN_2 = 4'd2;
  localparam logic [3:0] BIN_4 = 4'd4;
  localparam logic [3:0] BIN_8 = 4'd8;
  localparam logic [3:0] BIN_RESET = 4'd1;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_NAME_TRNC = 3'd2;
  localparam logic [2:0] ST_COMPRESS  = 3'd3;
  localparam logic [2:0] ST_DATA_TRNC = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // Output word kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [NAME_BITS-1:0] TABLE_NAMES [4] = '{
    "spectral/wlcal1b.wls",
    "spectral/wlcal2b.wls",
    "spectral/wlcal4b.wls",
    "spectral/wlcal8b.wls"
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_req;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic [2:0] status;
    logic       last;
  } out_word_t;

  // Work for the back end produced by one input byte
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay;
    logic       has_st;
    logic [2:0] st;
  } op_t;

  function automatic logic [1:0] table_sel(input logic [3:0] binning);
    logic [1:0] sel;
    sel = 2'd0;
    if (binning == BIN_2) sel = 2'd1;
    else if (binning == BIN_4) sel = 2'd2;
    else if (binning == BIN_8) sel = 2'd3;
    return sel;
  endfunction

  // First character sits in the top byte of each row
  function automatic logic [7:0] table_byte(input logic [1:0] sel, input logic [4:0] pos);
    logic [NAME_BITS-1:0] row;
    logic [7:0]           res;
    row = TABLE_NAMES[sel];
    res = 8'd0;
    for (int k = 0; k < NAME_BITS / 8; k++) begin
      if (pos == 5'(k)) res = row[NAME_BITS - 1 - 8 * k -: 8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/zsee_front.sv
// Front end: accepts archive bytes, walks the headers and decides what to emit.
// Depends on zsee_pkg; feeds zsee_queue with one op per producing byte.
`default_nettype none

module zsee_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [3:0]        cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire zsee_pkg::in_word_t in_word_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output zsee_pkg::op_t          q_op_o
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_NAME, PH_EXTRA, PH_SKIP, PH_PAYLOAD,
    PH_DONE_OK, PH_DONE_SIG, PH_DONE_COMP
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [3:0]    binning_q, binning_d;
  logic [4:0]    hdr_cnt_q, hdr_cnt_d;
  logic [15:0]   method_q, method_d;
  logic [31:0]   size_q, size_d;
  logic [15:0]   name_len_q, name_len_d;
  logic [15:0]   extra_len_q, extra_len_d;
  logic [31:0]   sig_q, sig_d;
  logic [15:0]   name_cnt_q, name_cnt_d;
  logic          match_q, match_d;
  logic [31:0]   skip_q, skip_d;

  logic          accept;
  logic          do_after_name;
  logic          do_after_extra;
  logic [4:0]    hdr_next;
  logic [7:0]    b;
  zsee_pkg::op_t op;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_word_i.data_byte;
  assign hdr_next   = hdr_cnt_q + 5'd1;

  always_comb begin
    phase_d        = phase_q;
    binning_d      = cfg_we_i ? cfg_data_i : binning_q;
    hdr_cnt_d      = hdr_cnt_q;
    method_d       = method_q;
    size_d         = size_q;
    name_len_d     = name_len_q;
    extra_len_d    = extra_len_q;
    sig_d          = sig_q;
    name_cnt_d     = name_cnt_q;
    match_d        = match_q;
    skip_d         = skip_q;
    do_after_name  = 1'b0;
    do_after_extra = 1'b0;
    op             = '0;

    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_cnt_q < 5'd4) sig_d = {b, sig_q[31:8]};
          unique case (hdr_cnt_q)
            zsee_pkg::OFS_METHOD:         method_d = {8'd0, b};
            zsee_pkg::OFS_METHOD + 5'd1:  method_d[15:8] = b;
            zsee_pkg::OFS_SIZE:           size_d = {24'd0, b};
            zsee_pkg::OFS_SIZE + 5'd1:    size_d[15:8] = b;
            zsee_pkg::OFS_SIZE + 5'd2:    size_d[23:16] = b;
            zsee_pkg::OFS_SIZE + 5'd3:    size_d[31:24] = b;
            zsee_pkg::OFS_NAME:           name_len_d = {8'd0, b};
            zsee_pkg::OFS_NAME + 5'd1:    name_len_d[15:8] = b;
            zsee_pkg::OFS_EXTRA:          extra_len_d = {8'd0, b};
            zsee_pkg::OFS_EXTRA + 5'd1:   extra_len_d[15:8] = b;
            default: ;
          endcase
          if (hdr_next == zsee_pkg::HDR_LEN) begin
            hdr_cnt_d = 5'd0;
            if (sig_d != zsee_pkg::ZIP_MAGIC) begin
              phase_d = PH_DONE_SIG;
            end else begin
              name_cnt_d    = 16'd0;
              match_d       = 1'b1;
              phase_d       = PH_NAME;
              do_after_name = (name_len_d == 16'd0);
            end
          end else begin
            hdr_cnt_d = hdr_next;
          end
        end
        PH_NAME: begin
          if (!(name_cnt_q < zsee_pkg::NAME_BYTES &&
                zsee_pkg::table_byte(zsee_pkg::table_sel(binning_q), name_cnt_q[4:0]) == b))
            match_d = 1'b0;
          name_cnt_d = name_cnt_q + 16'd1;
          if (name_cnt_d >= name_len_q) do_after_name = 1'b1;
        end
        PH_EXTRA: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == 32'd0) do_after_extra = 1'b1;
        end
        PH_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == 32'd0) begin
            phase_d   = PH_HEADER;
            hdr_cnt_d = 5'd0;
          end
        end
        PH_PAYLOAD: begin
          op.has_pay = 1'b1;
          op.pay     = b;
          skip_d     = skip_q - 32'd1;
          if (skip_d == 32'd0) phase_d = PH_DONE_OK;
        end
        default: ;
      endcase

      if (do_after_name) begin
        if (name_len_d != zsee_pkg::NAME_BYTES) match_d = 1'b0;
        if (match_d && method_d != 16'd0) begin
          phase_d = PH_DONE_COMP;
        end else begin
          phase_d = PH_EXTRA;
          skip_d  = {16'd0, extra_len_d};
          if (extra_len_d == 16'd0) do_after_extra = 1'b1;
        end
      end

      if (do_after_extra) begin
        skip_d = size_d;
        if (match_d) begin
          phase_d = (size_d != 32'd0) ? PH_PAYLOAD : PH_DONE_OK;
        end else if (size_d != 32'd0) begin
          phase_d = PH_SKIP;
        end else begin
          phase_d   = PH_HEADER;
          hdr_cnt_d = 5'd0;
        end
      end

      if (in_word_i.final_req) begin
        op.has_st = 1'b1;
        unique case (phase_d)
          PH_NAME:      op.st = zsee_pkg::ST_NAME_TRNC;
          PH_EXTRA:     op.st = match_d ? zsee_pkg::ST_DATA_TRNC : zsee_pkg::ST_NOT_FOUND;
          PH_PAYLOAD:   op.st = zsee_pkg::ST_DATA_TRNC;
          PH_DONE_OK:   op.st = zsee_pkg::ST_OK;
          PH_DONE_SIG:  op.st = zsee_pkg::ST_BAD_SIG;
          PH_DONE_COMP: op.st = zsee_pkg::ST_COMPRESS;
          default:      op.st = zsee_pkg::ST_NOT_FOUND;
        endcase
        // back to reset values for the next archive, binning kept
        phase_d     = PH_HEADER;
        hdr_cnt_d   = 5'd0;
        method_d    = 16'd0;
        size_d      = 32'd0;
        name_len_d  = 16'd0;
        extra_len_d = 16'd0;
        sig_d       = 32'd0;
        name_cnt_d  = 16'd0;
        match_d     = 1'b1;
        skip_d      = 32'd0;
      end
    end
  end

  assign q_push_o = accept && (op.has_pay || op.has_st);
  assign q_op_o   = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      binning_q   <= zsee_pkg::BIN_RESET;
      hdr_cnt_q   <= 5'd0;
      method_q    <= 16'd0;
      size_q      <= 32'd0;
      name_len_q  <= 16'd0;
      extra_len_q <= 16'd0;
      sig_q       <= 32'd0;
      name_cnt_q  <= 16'd0;
      match_q     <= 1'b1;
      skip_q      <= 32'd0;
    end else begin
      phase_q     <= phase_d;
      binning_q   <= binning_d;
      hdr_cnt_q   <= hdr_cnt_d;
      method_q    <= method_d;
      size_q      <= size_d;
      name_len_q  <= name_len_d;
      extra_len_q <= extra_len_d;
      sig_q       <= sig_d;
      name_cnt_q  <= name_cnt_d;
      match_q     <= match_d;
      skip_q      <= skip_d;
    end
  end

endmodule

`default_nettype wire

### sv/zsee_queue.sv
// Small FIFO of ops between the front and back ends.
// Depends on zsee_pkg for the op type and depth.
`default_nettype none

module zsee_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire zsee_pkg::op_t push_op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output zsee_pkg::op_t      head_o
);

  localparam int unsigned PW = zsee_pkg::QPTR_W;
  localparam int unsigned CW = zsee_pkg::QCNT_W;

  zsee_pkg::op_t  mem_q [zsee_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(zsee_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(zsee_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(zsee_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### sv/zsee_back.sv
// Back end: turns queued ops into output words through one output register.
// Depends on zsee_pkg; an op with a payload and a status yields two words.
`default_nettype none

module zsee_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire zsee_pkg::op_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output zsee_pkg::out_word_t out_word_o
);

  logic                valid_q, valid_d;
  zsee_pkg::out_word_t word_q, word_d;
  logic                pend_q, pend_d;   // status half of the last op still owed
  logic [2:0]          pend_st_q, pend_st_d;
  logic                can_load;

  assign can_load = !valid_q || out_ready_i;
  assign q_pop_o  = can_load && !pend_q && !q_empty_i;

  always_comb begin
    valid_d   = valid_q;
    word_d    = word_q;
    pend_d    = pend_q;
    pend_st_d = pend_st_q;
    if (can_load) begin
      valid_d = 1'b0;
      if (pend_q) begin
        valid_d = 1'b1;
        word_d  = '{kind: zsee_pkg::KIND_STATUS, payload: 8'd0, status: pend_st_q, last: 1'b1};
        pend_d  = 1'b0;
      end else if (!q_empty_i) begin
        valid_d = 1'b1;
        if (q_head_i.has_pay) begin
          word_d    = '{kind: zsee_pkg::KIND_PAYLOAD, payload: q_head_i.pay,
                        status: zsee_pkg::ST_OK, last: 1'b0};
          pend_d    = q_head_i.has_st;
          pend_st_d = q_head_i.st;
        end else begin
          word_d = '{kind: zsee_pkg::KIND_STATUS, payload: 8'd0, status: q_head_i.st,
                     last: 1'b1};
        end
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    pend_st_q <= pend_st_d;
  end

endmodule

`default_nettype wire

### sv/zip_stored_entry_extractor_top.sv
// ZIP stored-entry extractor, top level.
// Depends on zsee_pkg, zsee_front, zsee_queue and zsee_back.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o / in_word_i): one archive byte per
//    word, final_req set on the archive's last byte.
//  - Output channel (out_valid_o / out_ready_i / out_word_o): payload words
//    (kind 0) for the matching stored entry, then one status word (kind 1,
//    last 1) for each archive. On an error status, drop the payload words.
//  - cfg_we_i / cfg_data_i write the binning register (reset 1) while idle.
//  - Throughput: one byte per cycle while in_ready_o is high. The front
//    parser settles each byte in the cycle it is accepted; a 4-deep op
//    queue decouples it from the back. An accepted byte's op is written
//    into the queue, then loaded into the output register when that is free.
//  - A final byte that also carries payload produces two words, payload then
//    status; the output register is the limit of one word/cycle if not stalled.
//  - Receiver stall: the output register holds, the queue fills, and
//    in_ready_o drops only when all four queue slots are taken.
//  - Reset: parser goes to header-hunt state, queue and output empty,
//    binning = 1. No clearing pass is needed.
`default_nettype none

module zip_stored_entry_extractor_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [3:0]          cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire zsee_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output zsee_pkg::out_word_t      out_word_o
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  zsee_pkg::op_t q_op;
  zsee_pkg::op_t q_head;

  // Parser: header walk, name compare, skip counters, status decision
  zsee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (q_op)
  );

  zsee_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_o    (q_head)
  );

  // Output sequencer: splits payload+status ops into two words
  zsee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
